/* hw/rtl/ksl_pkg.sv */
`default_nettype none
package ksl_pkg;

   localparam int KEY_COLUMNS = 8;
   localparam int LCD_UNITS   = 6;

   localparam int KEY_IDX_W   = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;
   localparam int DIP_COLUMNS = 4;

   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_KEY_SET = 2'd2
   } command_type;

   typedef enum logic [0:0] {
      CSR_DIP_SWITCHES = 1'b0,
      CSR_POWER_ON     = 1'b1
   } csr_index_type;

   localparam logic [4:0] OFS_SCAN_MASK = 5'h00;
   localparam logic [4:0] OFS_KEY_READ  = 5'h02;
   localparam logic [4:0] OFS_LCD_CTRL  = 5'h06;
   localparam logic [4:0] OFS_STATUS    = 5'h08;
   localparam logic [4:0] OFS_LCD_DATA  = 5'h0A;
   localparam logic [4:0] OFS_LCD_CLK_B = 5'h0B;

   localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
   localparam logic [2:0] LCD_SEL_NONE  = 3'd0;
   localparam logic [2:0] LCD_SEL_OFF   = 3'd7;
   localparam logic [2:0] LCD_LAST_BIT  = 3'd7;

   localparam logic [3:0] DIP_RESET     = 4'd4;
   localparam logic       POWER_RESET   = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/ksl_ifs.sv */
`default_nettype none
interface ksl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [4:0] offset;
   logic [7:0] write_byte;
   logic [2:0] key_column;
   logic [9:0] key_bits;

   modport source (output valid, command, offset, write_byte, key_column, key_bits,
                   input ready);
   modport sink (input valid, command, offset, write_byte, key_column, key_bits,
                 output ready);
endinterface

interface ksl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       lcd_valid;
   logic [2:0] lcd_select;
   logic       lcd_is_command;
   logic [7:0] lcd_byte;

   modport source (output valid, read_byte, lcd_valid, lcd_select, lcd_is_command,
                   lcd_byte, input ready);
   modport sink (input valid, read_byte, lcd_valid, lcd_select, lcd_is_command,
                 lcd_byte, output ready);
endinterface
`default_nettype wire

/* hw/rtl/keyboard_scan_lcd_serial_io.sv */
`default_nettype none
// Keyboard scan, LCD serial and status I/O controller. Each item is a bus read,
// a bus write, a key-column update or a no-op, and each gives exactly one result
// item in the cycle after it is accepted. One item is taken every cycle: decode,
// the OR of the selected key columns and the LCD bit counter all sit between the
// input handshake and a single result register, and the input stays ready while
// that register is empty or being drained. Every eighth read of offset 10 or 11
// sends the latched LCD byte to the unit chosen by the control byte if it names
// a unit. Configuration writes (DIP switches, power line) take effect at once.
module keyboard_scan_lcd_serial_io (
   input  wire logic        clock,
   input  wire logic        reset,
   ksl_req_if.sink          req_bus,
   ksl_rsp_if.source        rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [3:0]  csr_wdata
);

   logic [3:0] dip_ff;
   logic       power_ff;
   logic [7:0] scan_mask_ff, scan_mask_in;
   logic [7:0] lcd_latch_ff, lcd_latch_in;
   logic [7:0] lcd_control_ff, lcd_control_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [9:0] key_matrix_ff [ksl_pkg::KEY_COLUMNS];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] read_byte_ff, read_byte_in;
   logic       lcd_valid_ff, lcd_valid_in;
   logic [2:0] lcd_select_ff, lcd_select_in;
   logic       lcd_is_command_ff, lcd_is_command_in;
   logic [7:0] lcd_byte_ff, lcd_byte_in;

   logic                 req_accept;
   logic                 key_write;
   logic [9:0]           selected_or;
   logic [2:0]           lcd_sel_code;
   logic                 lcd_unit_ok;
   ksl_pkg::command_type cmd;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign cmd           = ksl_pkg::command_type'(req_bus.command);

   // A column takes part when its scan mask bit is low; the DIP switches
   // stand in for return bit 9 of the first four columns.
   always_comb begin
      selected_or = '0;
      for (int c = 0; c < ksl_pkg::KEY_COLUMNS; c++) begin
         if (!scan_mask_ff[c]) begin
            if (c < ksl_pkg::DIP_COLUMNS) begin
               selected_or = selected_or | {dip_ff[c], key_matrix_ff[c][8:0]};
            end else begin
               selected_or = selected_or | key_matrix_ff[c];
            end
         end
      end
   end

   assign lcd_sel_code = lcd_control_ff[2:0];
   assign lcd_unit_ok  = (lcd_sel_code != ksl_pkg::LCD_SEL_NONE)
                      && (lcd_sel_code != ksl_pkg::LCD_SEL_OFF)
                      && (32'(lcd_sel_code) <= ksl_pkg::LCD_UNITS);

   assign key_write = req_accept && (cmd == ksl_pkg::CMD_KEY_SET)
                   && (32'(req_bus.key_column) < ksl_pkg::KEY_COLUMNS);

   always_comb begin
      scan_mask_in      = scan_mask_ff;
      lcd_latch_in      = lcd_latch_ff;
      lcd_control_in    = lcd_control_ff;
      bit_count_in      = bit_count_ff;
      read_byte_in      = '0;
      lcd_valid_in      = 1'b0;
      lcd_select_in     = '0;
      lcd_is_command_in = 1'b0;
      lcd_byte_in       = '0;
      case (cmd)
         ksl_pkg::CMD_READ: begin
            case (req_bus.offset)
               ksl_pkg::OFS_SCAN_MASK: read_byte_in = scan_mask_ff;
               ksl_pkg::OFS_KEY_READ:  read_byte_in = ~selected_or[7:0];
               ksl_pkg::OFS_STATUS:    read_byte_in = {power_ff, 5'b11111,
                                                       ~selected_or[9:8]};
               ksl_pkg::OFS_LCD_DATA, ksl_pkg::OFS_LCD_CLK_B: begin
                  read_byte_in = ksl_pkg::UNMAPPED_BYTE;
                  bit_count_in = bit_count_ff + 3'd1;
                  if (bit_count_ff == ksl_pkg::LCD_LAST_BIT && lcd_unit_ok) begin
                     lcd_valid_in      = 1'b1;
                     lcd_select_in     = lcd_sel_code - 3'd1;
                     lcd_is_command_in = lcd_control_ff[3];
                     lcd_byte_in       = lcd_latch_ff;
                  end
               end
               default: read_byte_in = ksl_pkg::UNMAPPED_BYTE;
            endcase
         end
         ksl_pkg::CMD_WRITE: begin
            case (req_bus.offset)
               ksl_pkg::OFS_SCAN_MASK: scan_mask_in   = req_bus.write_byte;
               ksl_pkg::OFS_LCD_CTRL:  lcd_control_in = req_bus.write_byte;
               ksl_pkg::OFS_LCD_DATA:  lcd_latch_in   = req_bus.write_byte;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         dip_ff         <= ksl_pkg::DIP_RESET;
         power_ff       <= ksl_pkg::POWER_RESET;
         scan_mask_ff   <= '0;
         lcd_latch_ff   <= '0;
         lcd_control_ff <= '0;
         bit_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < ksl_pkg::KEY_COLUMNS; c++) begin
            key_matrix_ff[c] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (ksl_pkg::csr_index_type'(csr_index))
               ksl_pkg::CSR_DIP_SWITCHES: dip_ff   <= csr_wdata;
               ksl_pkg::CSR_POWER_ON:     power_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_accept) begin
            scan_mask_ff   <= scan_mask_in;
            lcd_latch_ff   <= lcd_latch_in;
            lcd_control_ff <= lcd_control_in;
            bit_count_ff   <= bit_count_in;
         end
         if (key_write) begin
            key_matrix_ff[req_bus.key_column[ksl_pkg::KEY_IDX_W-1:0]] <= req_bus.key_bits;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         read_byte_ff      <= read_byte_in;
         lcd_valid_ff      <= lcd_valid_in;
         lcd_select_ff     <= lcd_select_in;
         lcd_is_command_ff <= lcd_is_command_in;
         lcd_byte_ff       <= lcd_byte_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.read_byte      = read_byte_ff;
   assign rsp_bus.lcd_valid      = lcd_valid_ff;
   assign rsp_bus.lcd_select     = lcd_select_ff;
   assign rsp_bus.lcd_is_command = lcd_is_command_ff;
   assign rsp_bus.lcd_byte       = lcd_byte_ff;

   // An LCD send only ever comes from a clock read, which returns all ones.
   a_lcd_on_clock_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && lcd_valid_ff |-> read_byte_ff == ksl_pkg::UNMAPPED_BYTE)
      else $error("LCD send on an item that is not a clock read");

   a_lcd_fields_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !lcd_valid_ff |->
         lcd_select_ff == 3'd0 && !lcd_is_command_ff && lcd_byte_ff == 8'd0)
      else $error("LCD fields not cleared without a send");

   a_lcd_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && lcd_valid_ff |-> 32'(lcd_select_ff) < ksl_pkg::LCD_UNITS)
      else $error("LCD unit index out of range");

   a_count_only_on_item: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(bit_count_ff))
      else $error("LCD bit counter moved without an item");

   a_send_wraps_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && lcd_valid_in |=> bit_count_ff == 3'd0)
      else $error("LCD send without the bit counter wrapping");

endmodule
`default_nettype wire

/* test/keyboard_scan_lcd_serial_io_tb.sv */
module keyboard_scan_lcd_serial_io_tb;

   // The command code that the block decodes as no operation.
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam logic [4:0] OFS_TOP  = 5'h1F;

   localparam logic [4:0] READ_OFFSETS [5] = '{ksl_pkg::OFS_SCAN_MASK, ksl_pkg::OFS_KEY_READ,
                                               ksl_pkg::OFS_STATUS, ksl_pkg::OFS_LCD_DATA,
                                               ksl_pkg::OFS_LCD_CLK_B};
   localparam logic [4:0] WRITE_OFFSETS [3] = '{ksl_pkg::OFS_SCAN_MASK, ksl_pkg::OFS_LCD_CTRL,
                                                ksl_pkg::OFS_LCD_DATA};
   localparam logic [3:0] DIP_PLAN [6]   = '{4'd0, 4'd15, 4'd9, 4'd6, 4'd15, 4'd0};
   localparam logic       POWER_PLAN [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

   typedef struct packed {
      logic [7:0] read_byte;
      logic       lcd_valid;
      logic [2:0] lcd_select;
      logic       lcd_is_command;
      logic [7:0] lcd_byte;
   } bus_reply_type;

   class key_lcd_mirror_type;
      logic [3:0] dip;
      logic       power;
      logic [7:0] scan_mask;
      logic [7:0] lcd_latch;
      logic [7:0] lcd_control;
      logic [2:0] clock_count;
      logic [9:0] columns [ksl_pkg::KEY_COLUMNS];
      bus_reply_type expected_replies [$];
      int unsigned failures;

      function new();
         dip         = ksl_pkg::DIP_RESET;
         power       = ksl_pkg::POWER_RESET;
         scan_mask   = '0;
         lcd_latch   = '0;
         lcd_control = '0;
         clock_count = '0;
         failures    = 0;
         foreach (columns[c]) columns[c] = '0;
      endfunction

      function void set_registers(logic [3:0] dip_value, logic power_value);
         dip   = dip_value;
         power = power_value;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      // OR of the return bits of every column whose scan mask bit is low.
      function logic [9:0] selected_keys();
         logic [9:0] acc;
         logic [9:0] v;
         acc = '0;
         for (int c = 0; c < ksl_pkg::KEY_COLUMNS; c++) begin
            if (!scan_mask[c]) begin
               v = columns[c];
               if (c < ksl_pkg::DIP_COLUMNS) v[9] = dip[c];
               acc |= v;
            end
         end
         return acc;
      endfunction

      function void take_request(logic [1:0] cmd, logic [4:0] offset, logic [7:0] wb,
                                 logic [2:0] col, logic [9:0] kb);
         bus_reply_type r;
         logic [9:0] keys;
         logic [2:0] unit;
         r = '0;
         case (cmd)
            ksl_pkg::CMD_READ: begin
               case (offset)
                  ksl_pkg::OFS_SCAN_MASK: r.read_byte = scan_mask;
                  ksl_pkg::OFS_KEY_READ: begin
                     keys = selected_keys();
                     r.read_byte = ~keys[7:0];
                  end
                  ksl_pkg::OFS_STATUS: begin
                     keys = selected_keys();
                     r.read_byte = {power, 5'b11111, ~keys[9:8]};
                  end
                  ksl_pkg::OFS_LCD_DATA, ksl_pkg::OFS_LCD_CLK_B: begin
                     clock_count = clock_count + 3'd1;
                     if (clock_count == 3'd0) begin
                        unit = lcd_control[2:0];
                        if (unit != ksl_pkg::LCD_SEL_NONE && unit != ksl_pkg::LCD_SEL_OFF &&
                            int'(unit) - 1 < ksl_pkg::LCD_UNITS) begin
                           r.lcd_valid      = 1'b1;
                           r.lcd_select     = unit - 3'd1;
                           r.lcd_is_command = lcd_control[3];
                           r.lcd_byte       = lcd_latch;
                        end
                     end
                     r.read_byte = ksl_pkg::UNMAPPED_BYTE;
                  end
                  default: r.read_byte = ksl_pkg::UNMAPPED_BYTE;
               endcase
            end
            ksl_pkg::CMD_WRITE: begin
               case (offset)
                  ksl_pkg::OFS_SCAN_MASK: scan_mask = wb;
                  ksl_pkg::OFS_LCD_CTRL: lcd_control = wb;
                  ksl_pkg::OFS_LCD_DATA: lcd_latch = wb;
                  default: ;
               endcase
            end
            ksl_pkg::CMD_KEY_SET: begin
               if (int'(col) < ksl_pkg::KEY_COLUMNS) columns[col] = kb;
            end
            default: ;
         endcase
         expected_replies.push_back(r);
      endfunction

      function void report(string field, logic [7:0] want, logic [7:0] got);
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         failures++;
      endfunction

      function void match_reply(bus_reply_type got);
         bus_reply_type want;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected result item, expected none, got %0h", $time, got);
            failures++;
            return;
         end
         want = expected_replies.pop_front();
         if (got.read_byte !== want.read_byte)
            report("read_byte", want.read_byte, got.read_byte);
         if (got.lcd_valid !== want.lcd_valid)
            report("lcd_valid", 8'(want.lcd_valid), 8'(got.lcd_valid));
         if (got.lcd_select !== want.lcd_select)
            report("lcd_select", 8'(want.lcd_select), 8'(got.lcd_select));
         if (got.lcd_is_command !== want.lcd_is_command)
            report("lcd_is_command", 8'(want.lcd_is_command), 8'(got.lcd_is_command));
         if (got.lcd_byte !== want.lcd_byte)
            report("lcd_byte", want.lcd_byte, got.lcd_byte);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   ksl_pkg::csr_index_type csr_index = ksl_pkg::CSR_DIP_SWITCHES;
   logic [3:0] csr_wdata = '0;

   ksl_req_if req_bus ();
   ksl_rsp_if rsp_bus ();

   key_lcd_mirror_type mirror = new();
   bus_reply_type seen;

   bit sender_no_gaps   = 1'b0;
   bit receiver_no_gaps = 1'b0;
   int rsp_hold_cycles  = 0;
   int useful_items     = 0;

   keyboard_scan_lcd_serial_io i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.read_byte, rsp_bus.lcd_valid, rsp_bus.lcd_select,
                    rsp_bus.lcd_is_command, rsp_bus.lcd_byte};
            mirror.match_reply(seen);
         end
         if (req_bus.valid && req_bus.ready)
            mirror.take_request(req_bus.command, req_bus.offset, req_bus.write_byte,
                                req_bus.key_column, req_bus.key_bits);
      end
   end

   initial begin : result_sink
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = receiver_no_gaps ? 0 : $urandom_range(0, 11);
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_item(input logic [1:0] cmd, input logic [4:0] offset,
                            input logic [7:0] wb, input logic [2:0] col,
                            input logic [9:0] kb);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.offset     <= offset;
      req_bus.write_byte <= wb;
      req_bus.key_column <= col;
      req_bus.key_bits   <= kb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!(cmd == CMD_NONE || (cmd == ksl_pkg::CMD_WRITE && offset != ksl_pkg::OFS_SCAN_MASK &&
                                offset != ksl_pkg::OFS_LCD_CTRL &&
                                offset != ksl_pkg::OFS_LCD_DATA)))
         useful_items++;
   endtask

   // Drops valid, then lets every outstanding result drain before going on.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(input logic [3:0] dip_value, input logic power_value);
      logic [2:0] filler;
      filler = 3'($urandom_range(0, 7));
      csr_we    <= 1'b1;
      csr_index <= ksl_pkg::CSR_DIP_SWITCHES;
      csr_wdata <= dip_value;
      @(posedge clock);
      csr_index <= ksl_pkg::CSR_POWER_ON;
      csr_wdata <= {filler, power_value};
      @(posedge clock);
      csr_we <= 1'b0;
      mirror.set_registers(dip_value, power_value);
   endtask

   task automatic send_read(input logic [4:0] offset);
      send_item(ksl_pkg::CMD_READ, offset, 8'($urandom_range(0, 255)),
                3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
   endtask

   task automatic send_key_set();
      send_item(ksl_pkg::CMD_KEY_SET, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
   endtask

   // Control and data byte, then a run of serial clock reads. Most runs are full
   // length so that a byte goes out; the rest stop short.
   task automatic lcd_sequence();
      logic [2:0] unit;
      int reads;
      unit = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 6))
                                        : ($urandom_range(0, 1) ? ksl_pkg::LCD_SEL_OFF
                                                                : ksl_pkg::LCD_SEL_NONE);
      send_item(ksl_pkg::CMD_WRITE, ksl_pkg::OFS_LCD_CTRL,
                {4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), unit},
                3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
      send_item(ksl_pkg::CMD_WRITE, ksl_pkg::OFS_LCD_DATA, 8'($urandom_range(0, 255)),
                3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
      reads = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 8;
      for (int i = 0; i < reads; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_key_set();
         send_read($urandom_range(0, 1) ? ksl_pkg::OFS_LCD_CLK_B : ksl_pkg::OFS_LCD_DATA);
      end
   endtask

   task automatic random_step();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         lcd_sequence();
      end else if (kind < 35) begin
         send_key_set();
      end else if (kind < 55) begin
         send_item(ksl_pkg::CMD_WRITE,
                   ($urandom_range(0, 4) != 0) ? WRITE_OFFSETS[2'($urandom_range(0, 2))]
                                               : 5'($urandom_range(0, 31)),
                   8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                   10'($urandom_range(0, 1023)));
      end else if (kind < 97) begin
         send_read(($urandom_range(0, 4) != 0) ? READ_OFFSETS[3'($urandom_range(0, 4))]
                                               : 5'($urandom_range(0, 31)));
      end else begin
         send_item(CMD_NONE, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
      end
   endtask

   initial begin
      int target;
      logic [3:0] dip_value;
      req_bus.valid      = 1'b0;
      req_bus.command    = ksl_pkg::CMD_READ;
      req_bus.offset     = '0;
      req_bus.write_byte = '0;
      req_bus.key_column = '0;
      req_bus.key_bits   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the registers still at their reset values.
      send_read(ksl_pkg::OFS_SCAN_MASK);
      send_read(ksl_pkg::OFS_KEY_READ);
      send_read(ksl_pkg::OFS_STATUS);
      send_item(ksl_pkg::CMD_KEY_SET, 5'd0, 8'h00, 3'd0, 10'h3FF);
      send_item(ksl_pkg::CMD_KEY_SET, 5'd0, 8'hFF, 3'd7, 10'h155);
      send_item(ksl_pkg::CMD_KEY_SET, 5'd0, 8'h00, 3'd3, 10'h000);
      send_read(ksl_pkg::OFS_KEY_READ);
      send_read(ksl_pkg::OFS_STATUS);
      // Only column 0 selected: its stored bit 9 must give way to the switch.
      send_item(ksl_pkg::CMD_WRITE, ksl_pkg::OFS_SCAN_MASK, 8'hFE, 3'd0, 10'h000);
      send_read(ksl_pkg::OFS_STATUS);
      send_read(ksl_pkg::OFS_SCAN_MASK);
      send_item(ksl_pkg::CMD_WRITE, ksl_pkg::OFS_LCD_CTRL, 8'h0B, 3'd0, 10'h000);
      send_item(ksl_pkg::CMD_WRITE, ksl_pkg::OFS_LCD_DATA, 8'hA5, 3'd0, 10'h000);
      for (int i = 0; i < 8; i++)
         send_read(i[0] ? ksl_pkg::OFS_LCD_CLK_B : ksl_pkg::OFS_LCD_DATA);
      send_item(CMD_NONE, OFS_TOP, 8'hFF, 3'd7, 10'h3FF);
      send_read(ksl_pkg::OFS_LCD_CTRL);
      send_item(ksl_pkg::CMD_WRITE, OFS_TOP, 8'h00, 3'd0, 10'h000);
      send_read(OFS_TOP);

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         dip_value = (phase == 2) ? 4'($urandom_range(0, 15)) : DIP_PLAN[phase];
         configure(dip_value, POWER_PLAN[phase]);
         sender_no_gaps   = (phase == 2 || phase == 3);
         receiver_no_gaps = (phase == 2);
         // Long receiver hold-off while items keep coming, to back up the input.
         if (phase == 3) rsp_hold_cycles = 80;
         target = useful_items + 160;
         while (useful_items < target) begin
            random_step();
            if (phase == 4 && useful_items == target - 80) wait_drained();
         end
      end

      wait_drained();
      if (mirror.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
